/* rtl/gbae_pkg.sv */
// shared types and codes for the group-by aggregation engine
package gbae_pkg;

	// aggregate codes
	localparam logic [2:0] OP_COUNT = 3'd0;
	localparam logic [2:0] OP_SUM   = 3'd1;
	localparam logic [2:0] OP_MIN   = 3'd2;
	localparam logic [2:0] OP_MAX   = 3'd3;
	localparam logic [2:0] OP_AVG   = 3'd4;

	// configuration register indexes
	localparam logic REG_AGG_OP       = 1'b0;
	localparam logic REG_GROUP_ENABLE = 1'b1;

	// request codes
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam int DIV_W = 48;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] group_key;
		logic signed [31:0] agg_value;
	} in_item_t;

	typedef struct packed {
		logic               row_valid;
		logic signed [31:0] out_key;
		logic signed [47:0] agg_result;
		logic               last_row;
		logic [31:0]        dropped_rows;
	} out_item_t;

	// one table entry held by a cell
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] sum;
		logic [31:0] min;
		logic [31:0] max;
		logic [31:0] cnt;
	} entry_t;

	// per-cell control from the top level
	typedef struct packed {
		logic merge;
		logic open;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/gbae_cell.sv */
// one table cell: holds a group entry, updates it, and shifts toward cell zero on flush
module gbae_cell (
	input  logic               clk,
	input  gbae_pkg::cell_ctl_t ctl,
	input  logic [31:0]        row_key,
	input  logic [31:0]        row_val,
	input  gbae_pkg::entry_t   nxt,
	output gbae_pkg::entry_t   ent,
	output logic               key_eq
);

	gbae_pkg::entry_t ent_q;

	assign ent    = ent_q;
	assign key_eq = (ent_q.key == row_key);

	// entry update: shift, open or merge
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ent_q <= nxt;
		end else if (ctl.open) begin
			ent_q.key <= row_key;
			ent_q.sum <= row_val;
			ent_q.min <= row_val;
			ent_q.max <= row_val;
			ent_q.cnt <= 32'd1;
		end else if (ctl.merge) begin
			if (ent_q.cnt == 32'd0) begin
				ent_q.min <= row_val;
				ent_q.max <= row_val;
			end else begin
				if ($signed(row_val) < $signed(ent_q.min)) ent_q.min <= row_val;
				if ($signed(row_val) > $signed(ent_q.max)) ent_q.max <= row_val;
			end
			ent_q.sum <= ent_q.sum + row_val;
			ent_q.cnt <= ent_q.cnt + 32'd1;
		end
	end

endmodule

/* rtl/gbae_div.sv */
// restoring divider, one quotient bit per cycle, for the average
module gbae_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [47:0] quot
);

	localparam int CW = $clog2(gbae_pkg::DIV_W + 1);

	logic [31:0]   rem_q;
	logic [47:0]   quo_q;
	logic [31:0]   dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   sh;
	logic [32:0]   diff;

	assign sh   = {rem_q, quo_q[47]};
	assign diff = sh - {1'b0, dsr_q};
	assign done = done_q;
	assign quot = quo_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(gbae_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= sh[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/group_by_aggregation_engine_core.sv */
// group-by aggregation engine: top level with cell chain, flush sequencer and divider
// data rows: one per cycle while idle, table updated in the cycle of acceptance
// end item: one result per group (one in all when grouping is off or the table is empty);
//   each is loaded, for average divided by the bit-serial divider, then put out; input
//   stalls during the flush; results wait in an output register
// reset clears group count, drop counter, sequencer, config and out_valid; entries undefined
module group_by_aggregation_engine_core #(
	parameter int MAX_GROUPS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gbae_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gbae_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [2:0]           cfg_wdata
);

	localparam int UW = $clog2(MAX_GROUPS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_PUT  = 2'd3;

	logic [1:0]          state_q;
	logic [2:0]          agg_op_q;
	logic                group_en_q;
	logic [UW-1:0]       used_q;
	logic [31:0]         drop_q;
	logic [UW-1:0]       rem_q;
	logic                fl_ge_q;
	logic                fl_has_q;
	logic                neg_q;
	logic signed [47:0]  res_q;
	logic                out_valid_q;
	gbae_pkg::out_item_t out_q;

	gbae_pkg::entry_t    ents [MAX_GROUPS];
	gbae_pkg::cell_ctl_t ctls [MAX_GROUPS];
	logic [MAX_GROUPS-1:0] key_eq;
	logic [MAX_GROUPS-1:0] hit;
	logic                in_fire;
	logic                row_fire;
	logic                any_hit;
	logic                out_free;
	logic                put_fire;
	logic                is_last;
	logic [31:0]         row_key;
	logic                div_start;
	logic                div_done;
	logic [47:0]         div_quot;
	logic [31:0]         abs_sum;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign row_fire  = in_fire && (in_item.req_type == gbae_pkg::REQ_DATA);
	assign out_free  = !out_valid_q || out_ready;
	assign put_fire  = (state_q == S_PUT) && out_free;
	assign is_last   = (rem_q == UW'(1));
	assign any_hit   = |hit;
	assign row_key   = group_en_q ? in_item.group_key : 32'd0;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign abs_sum   = ents[0].sum[31] ? (32'd0 - ents[0].sum) : ents[0].sum;

	// chain of cells
	for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
		gbae_pkg::entry_t nxt;
		if (i == MAX_GROUPS - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ents[i+1];
		end

		assign hit[i] = (UW'(i) < used_q) && key_eq[i];

		// per-cell control
		always_comb begin
			ctls[i].shift = put_fire;
			ctls[i].open  = 1'b0;
			ctls[i].merge = 1'b0;
			if (row_fire) begin
				if (group_en_q) begin
					ctls[i].merge = hit[i];
					ctls[i].open  = !any_hit && (used_q == UW'(i));
				end else if (i == 0) begin
					ctls[i].open  = (used_q == '0);
					ctls[i].merge = (used_q != '0);
				end
			end
		end

		gbae_cell u_cell (
			.clk     (clk),
			.ctl     (ctls[i]),
			.row_key (row_key),
			.row_val (in_item.agg_value),
			.nxt     (nxt),
			.ent     (ents[i]),
			.key_eq  (key_eq[i])
		);
	end

	assign div_start = (state_q == S_LOAD) && fl_has_q && (agg_op_q == gbae_pkg::OP_AVG)
		&& (ents[0].cnt != 32'd0);

	gbae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({abs_sum, 16'd0}),
		.divisor  (ents[0].cnt),
		.done     (div_done),
		.quot     (div_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_op_q   <= gbae_pkg::OP_COUNT;
			group_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gbae_pkg::REG_AGG_OP:       agg_op_q   <= cfg_wdata;
				gbae_pkg::REG_GROUP_ENABLE: group_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// group count, drop counter and flush sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			drop_q   <= '0;
			rem_q    <= '0;
			fl_ge_q  <= 1'b0;
			fl_has_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (row_fire) begin
						if (!group_en_q) begin
							if (used_q == '0) used_q <= UW'(1);
						end else if (!any_hit) begin
							if (used_q != UW'(MAX_GROUPS)) used_q <= used_q + UW'(1);
							else if (drop_q != 32'hFFFF_FFFF) drop_q <= drop_q + 32'd1;
						end
					end else if (in_fire) begin
						fl_ge_q  <= group_en_q;
						fl_has_q <= (used_q != '0);
						rem_q    <= (group_en_q && used_q != '0) ? used_q : UW'(1);
						state_q  <= S_LOAD;
					end
				end
				S_LOAD: state_q <= div_start ? S_DIV : S_PUT;
				S_DIV:  if (div_done) state_q <= S_PUT;
				S_PUT: begin
					if (out_free) begin
						rem_q <= rem_q - UW'(1);
						if (is_last) begin
							used_q  <= '0;
							drop_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// aggregate value of the head cell
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			neg_q <= ents[0].sum[31];
			if (!fl_has_q) begin
				res_q <= '0;
			end else begin
				unique case (agg_op_q)
					gbae_pkg::OP_COUNT: res_q <= {16'd0, ents[0].cnt};
					gbae_pkg::OP_SUM:   res_q <= 48'(signed'(ents[0].sum));
					gbae_pkg::OP_MIN:   res_q <= 48'(signed'(ents[0].min));
					gbae_pkg::OP_MAX:   res_q <= 48'(signed'(ents[0].max));
					default:            res_q <= '0;
				endcase
			end
		end else if (state_q == S_DIV && div_done) begin
			res_q <= neg_q ? (48'd0 - div_quot) : div_quot;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_fire) begin
			out_q.row_valid    <= fl_ge_q ? fl_has_q : 1'b1;
			out_q.out_key      <= (fl_ge_q && fl_has_q) ? ents[0].key : 32'd0;
			out_q.agg_result   <= res_q;
			out_q.last_row     <= is_last;
			out_q.dropped_rows <= drop_q;
		end
	end

	// table never holds more groups than cells
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_GROUPS))
		else $error("group count beyond table size");

	// the last result of a flush clears table and drop counter
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		put_fire && is_last |=> used_q == '0 && drop_q == '0 && state_q == S_IDLE)
		else $error("flush did not clear the table");

	// a flush always has results left while it runs
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> rem_q != '0)
		else $error("flush running with no results left");

endmodule
